// File: rtl/core/rdcw_pkg.sv
// ----------------------------------------------------------------------------
// rdcw_pkg
// Shared types and constants for the recent distinct cell window.
// ----------------------------------------------------------------------------
package rdcw_pkg;

    localparam int POS_W  = 6;
    localparam int CELL_W = 16;
    localparam int EP_W   = 7;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [EP_W-1:0]   t_ep;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_CMP  = 2'd1,
        OP_UPD  = 2'd2,
        OP_ROT  = 2'd3
    } t_op;

    localparam logic ACT_CELL = 1'b0;
    localparam logic ACT_STOP = 1'b1;

    typedef struct packed {
        t_op   op;
        t_cell id;
        t_pos  len;
        t_pos  last_idx;
        logic  full;
    } t_chain_ctl;

endpackage

// File: rtl/core/recent_distinct_cell_window_top.sv
// ----------------------------------------------------------------------------
// recent_distinct_cell_window_top
// Move-to-end window of recent distinct cell ids, streamed out per item.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid o_in_ready i_action i_cell_id  | word in
//  out     | o_out_valid i_out_ready o_entry_cell      | word out
//          | o_entry_position o_cell_was_new o_last    |
//  cfg     | i_cfg_we i_cfg_data                       | write only
//
//  A cell word passes through compare and update, then emits one word per
//  window entry, as the cell row rotates one place per output word.
//  A stop word clears the length and emits no words. Output stalls hold the rotation in place.
//  Reset clears the length and control state, not the slots; slots past the length are never read.
// ----------------------------------------------------------------------------
module recent_distinct_cell_window_top #(
    parameter int MAX_EPISODE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  rdcw_pkg::t_cell      i_cell_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rdcw_pkg::t_cell      o_entry_cell,
    output rdcw_pkg::t_pos       o_entry_position,
    output logic                 o_cell_was_new,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  rdcw_pkg::t_ep        i_cfg_data
);

    localparam int DEPTH = MAX_EPISODE - 1;
    localparam rdcw_pkg::t_ep EP_MAX = rdcw_pkg::t_ep'(MAX_EPISODE);
    localparam rdcw_pkg::t_ep EP_MIN = rdcw_pkg::t_ep'(2);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state               r_state;
    rdcw_pkg::t_ep        r_ep;
    rdcw_pkg::t_pos       r_len;
    rdcw_pkg::t_pos       r_pos;
    rdcw_pkg::t_cell      r_cell;
    logic                 r_new;
    logic                 r_o_valid;
    rdcw_pkg::t_cell      r_o_cell;
    rdcw_pkg::t_pos       r_o_pos;
    logic                 r_o_new;
    logic                 r_o_last;

    rdcw_pkg::t_ep        ep_clamp;
    rdcw_pkg::t_pos       cap;
    rdcw_pkg::t_pos       last_idx;
    logic                 full;
    logic                 found;
    logic                 load_ok;
    logic                 emit_last;
    rdcw_pkg::t_cell      head;
    rdcw_pkg::t_chain_ctl ctl;

    always_comb begin
        if (r_ep < EP_MIN) begin
            ep_clamp = EP_MIN;
        end else if (r_ep > EP_MAX) begin
            ep_clamp = EP_MAX;
        end else begin
            ep_clamp = r_ep;
        end
    end

    assign cap       = rdcw_pkg::t_pos'(ep_clamp - rdcw_pkg::t_ep'(1));
    assign last_idx  = r_len - rdcw_pkg::t_pos'(1);
    assign full      = (r_len >= cap);
    assign load_ok   = !r_o_valid || i_out_ready;
    assign emit_last = (r_pos == last_idx);

    always_comb begin
        ctl.id       = r_cell;
        ctl.len      = r_len;
        ctl.last_idx = last_idx;
        ctl.full     = full;
        case (r_state)
            ST_CMP:  ctl.op = rdcw_pkg::OP_CMP;
            ST_UPD:  ctl.op = rdcw_pkg::OP_UPD;
            ST_EMIT: ctl.op = load_ok ? rdcw_pkg::OP_ROT : rdcw_pkg::OP_HOLD;
            default: ctl.op = rdcw_pkg::OP_HOLD;
        endcase
    end

    rdcw_chain #(
        .DEPTH(DEPTH)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .o_found(found),
        .o_head (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ep      <= rdcw_pkg::t_ep'(8);
            r_len     <= '0;
            r_pos     <= '0;
            r_new     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ep <= i_cfg_data;
            end
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_action == rdcw_pkg::ACT_STOP) begin
                            r_len <= '0;
                        end else begin
                            r_state <= ST_CMP;
                        end
                    end
                end
                ST_CMP: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (!found && !full) begin
                        r_len <= r_len + rdcw_pkg::t_pos'(1);
                    end
                    r_new   <= !found;
                    r_pos   <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (load_ok) begin
                        r_o_valid <= 1'b1;
                        r_pos     <= r_pos + rdcw_pkg::t_pos'(1);
                        if (emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_cell <= i_cell_id;
        end
        if (r_state == ST_EMIT && load_ok) begin
            r_o_cell <= head;
            r_o_pos  <= r_pos;
            r_o_new  <= r_new;
            r_o_last <= emit_last;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_entry_cell     = r_o_cell;
    assign o_entry_position = r_o_pos;
    assign o_cell_was_new   = r_o_new;
    assign o_last           = r_o_last;

endmodule

// File: rtl/core/rdcw_cell.sv
// ----------------------------------------------------------------------------
// rdcw_cell
// One window slot: holds an id, compares it, shifts from its neighbor.
// ----------------------------------------------------------------------------
module rdcw_cell #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  rdcw_pkg::t_chain_ctl i_ctl,
    input  logic                 i_found,
    input  logic                 i_after_hit,
    input  rdcw_pkg::t_cell      i_next,
    input  rdcw_pkg::t_cell      i_head,
    output rdcw_pkg::t_cell      o_entry,
    output logic                 o_match
);

    localparam rdcw_pkg::t_pos C_IDX = rdcw_pkg::t_pos'(IDX);

    rdcw_pkg::t_cell r_entry;
    rdcw_pkg::t_cell n_entry;
    logic            is_last;
    logic            before_last;
    logic            tail;

    assign is_last     = (C_IDX == i_ctl.last_idx);
    assign before_last = (C_IDX < i_ctl.last_idx);
    assign tail        = i_found || i_ctl.full;
    assign o_match     = (r_entry == i_ctl.id) && (C_IDX < i_ctl.len);
    assign o_entry     = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            rdcw_pkg::OP_UPD: begin
                if (tail) begin
                    if (is_last) begin
                        n_entry = i_ctl.id;
                    end else if (before_last && (i_after_hit || !i_found)) begin
                        n_entry = i_next;
                    end
                end else if (C_IDX == i_ctl.len) begin
                    n_entry = i_ctl.id;
                end
            end
            rdcw_pkg::OP_ROT: begin
                if (is_last) begin
                    n_entry = i_head;
                end else if (before_last) begin
                    n_entry = i_next;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/core/rdcw_chain.sv
// ----------------------------------------------------------------------------
// rdcw_chain
// Row of window cells with registered match vector and prefix-OR of hits.
// ----------------------------------------------------------------------------
module rdcw_chain #(
    parameter int DEPTH = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdcw_pkg::t_chain_ctl i_ctl,
    output logic                 o_found,
    output rdcw_pkg::t_cell      o_head
);

    localparam int STEPS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rdcw_pkg::t_cell  entry [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] r_hit;
    logic [DEPTH-1:0] pre [STEPS+1];
    logic [DEPTH-1:0] after_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (i_ctl.op == rdcw_pkg::OP_CMP) begin
            r_hit <= match;
        end
    end

    // log-depth prefix OR
    always_comb begin
        pre[0] = r_hit;
        for (int s = 0; s < STEPS; s++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << s)) begin
                    pre[s+1][i] = pre[s][i] | pre[s][i - (1 << s)];
                end else begin
                    pre[s+1][i] = pre[s][i];
                end
            end
        end
    end

    assign after_hit = pre[STEPS];
    assign o_found   = |r_hit;
    assign o_head    = entry[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        rdcw_pkg::t_cell nxt;
        if (g < DEPTH - 1) begin : g_mid
            assign nxt = entry[g+1];
        end else begin : g_end
            assign nxt = entry[g];
        end
        rdcw_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_found    (o_found),
            .i_after_hit(after_hit[g]),
            .i_next     (nxt),
            .i_head     (entry[0]),
            .o_entry    (entry[g]),
            .o_match    (match[g])
        );
    end

endmodule

// File: rtl/core/rdcw_checker.sv
// ----------------------------------------------------------------------------
// rdcw_checker
// Port-level checks on the window top, attached by bind.
// ----------------------------------------------------------------------------
module rdcw_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            i_action,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input rdcw_pkg::t_pos  o_entry_position,
    input logic            o_cell_was_new,
    input logic            o_last
);

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready while a run is still being emitted");

    a_cell_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == rdcw_pkg::ACT_CELL) |=> !o_in_ready)
        else $error("cell word did not start processing");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            o_out_valid &&
            (o_entry_position == $past(o_entry_position) + rdcw_pkg::t_pos'(1)))
        else $error("window positions not consecutive");

    a_new_flag_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            (o_cell_was_new == $past(o_cell_was_new)))
        else $error("new flag changed within a run");

endmodule

bind recent_distinct_cell_window_top rdcw_checker u_rdcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_action        (i_action),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_entry_position(o_entry_position),
    .o_cell_was_new  (o_cell_was_new),
    .o_last          (o_last)
);

// File: bench/tb_recent_distinct_cell_window_top.sv
// ----------------------------------------------------------------------------
// tb_recent_distinct_cell_window_top
// Self-checking bench for the move-to-end window of recent distinct cell ids.
// A scoreboard mirrors the window and queues the expected output words per
// cell word. The words are checked in order against the output channel while
// both channels idle at random. The bench runs a directed set of edge cases,
// then random phases over several episode lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_recent_distinct_cell_window_top;

    localparam int MAX_EP = 64;

    typedef struct packed {
        rdcw_pkg::t_cell id;
        rdcw_pkg::t_pos  pos;
        logic            was_new;
        logic            is_last;
    } t_window_entry;

    class cell_window_scoreboard;
        rdcw_pkg::t_cell window_q[$];
        t_window_entry   pending_entries[$];
        rdcw_pkg::t_ep   episode_len;
        int              errors;

        function new();
            episode_len = 7'd8;
            errors      = 0;
        endfunction

        function void set_length(rdcw_pkg::t_ep value);
            episode_len = value;
        endfunction

        function int unsigned capacity();
            int unsigned e;
            e = episode_len;
            if (e < 2) e = 2;
            if (e > MAX_EP) e = MAX_EP;
            return e - 1;
        endfunction

        // update the mirrored window and queue the words it emits
        function void note_word(logic act, rdcw_pkg::t_cell id);
            int            hit;
            int            i;
            t_window_entry ent;
            hit = -1;
            if (act == rdcw_pkg::ACT_STOP) begin
                window_q.delete();
                return;
            end
            for (i = 0; i < window_q.size(); i++) begin
                if (hit < 0 && window_q[i] == id) hit = i;
            end
            if (hit >= 0) begin
                window_q.delete(hit);
            end else if (window_q.size() >= capacity()) begin
                void'(window_q.pop_front());
            end
            window_q.push_back(id);
            for (i = 0; i < window_q.size(); i++) begin
                ent.id      = window_q[i];
                ent.pos     = rdcw_pkg::t_pos'(i);
                ent.was_new = (hit < 0);
                ent.is_last = (i == window_q.size() - 1);
                pending_entries.push_back(ent);
            end
        endfunction

        function void check_word(rdcw_pkg::t_cell id, rdcw_pkg::t_pos pos,
                                 logic was_new, logic is_last);
            t_window_entry exp_e;
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected word cell=%h pos=%0d new=%b last=%b",
                         $time, id, pos, was_new, is_last);
                errors++;
                return;
            end
            exp_e = pending_entries.pop_front();
            if (exp_e.id !== id) begin
                $display("%0t: entry_cell expected %h actual %h", $time, exp_e.id, id);
                errors++;
            end
            if (exp_e.pos !== pos) begin
                $display("%0t: entry_position expected %0d actual %0d", $time, exp_e.pos, pos);
                errors++;
            end
            if (exp_e.was_new !== was_new) begin
                $display("%0t: cell_was_new expected %b actual %b",
                         $time, exp_e.was_new, was_new);
                errors++;
            end
            if (exp_e.is_last !== is_last) begin
                $display("%0t: last expected %b actual %b", $time, exp_e.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            i_action    = rdcw_pkg::ACT_CELL;
    rdcw_pkg::t_cell i_cell_id   = '0;
    logic            i_out_ready = 1'b0;
    logic            i_cfg_we    = 1'b0;
    rdcw_pkg::t_ep   i_cfg_data  = 7'd8;
    logic            o_in_ready;
    logic            o_out_valid;
    rdcw_pkg::t_cell o_entry_cell;
    rdcw_pkg::t_pos  o_entry_position;
    logic            o_cell_was_new;
    logic            o_last;

    bit calm = 1'b0;
    cell_window_scoreboard sb;

    recent_distinct_cell_window_top #(
        .MAX_EPISODE (MAX_EP)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_cell_id        (i_cell_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_entry_cell     (o_entry_cell),
        .o_entry_position (o_entry_position),
        .o_cell_was_new   (o_cell_was_new),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_entry_cell, o_entry_position, o_cell_was_new, o_last);
        end
    end

    task automatic send_word(input logic act, input rdcw_pkg::t_cell id);
        if (!calm && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_action   <= act;
        i_cell_id  <= id;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(act, id);
    endtask

    // hold input until every expected word is out, then let the block settle
    task automatic drain_window_out();
        i_in_valid <= 1'b0;
        while (sb.pending_entries.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_length(input rdcw_pkg::t_ep value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_length(value);
    endtask

    task automatic run_phase(input rdcw_pkg::t_ep cfg, input int n_words, input bit quiet,
                             input int stop_pct);
        rdcw_pkg::t_cell pool[66];
        int              psize;
        int              k;
        int              sel;
        drain_window_out();
        write_length(cfg);
        calm  = quiet;
        psize = sb.capacity() + 2;
        for (k = 0; k < psize; k++) pool[k] = rdcw_pkg::t_cell'($urandom);
        for (k = 0; k < n_words; k++) begin
            sel = $urandom_range(99);
            if (sel < stop_pct) begin
                send_word(rdcw_pkg::ACT_STOP, rdcw_pkg::t_cell'($urandom));
            end else if (sel < stop_pct + 10) begin
                send_word(rdcw_pkg::ACT_CELL, rdcw_pkg::t_cell'($urandom));
            end else if (sel < stop_pct + 35) begin
                send_word(rdcw_pkg::ACT_CELL, pool[$urandom_range(psize - 1)]);
            end else begin
                // cyclic walk keeps the window full and evicting
                send_word(rdcw_pkg::ACT_CELL, pool[k % psize]);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default length 8: capacity 7
        send_word(rdcw_pkg::ACT_STOP, 16'hFFFF);
        send_word(rdcw_pkg::ACT_CELL, 16'h0000);
        send_word(rdcw_pkg::ACT_CELL, 16'hFFFF);
        send_word(rdcw_pkg::ACT_CELL, 16'h0000);
        send_word(rdcw_pkg::ACT_CELL, 16'h0000);
        send_word(rdcw_pkg::ACT_CELL, 16'h1111);
        send_word(rdcw_pkg::ACT_CELL, 16'h2222);
        send_word(rdcw_pkg::ACT_CELL, 16'h8000);
        send_word(rdcw_pkg::ACT_CELL, 16'h7FFF);
        send_word(rdcw_pkg::ACT_CELL, 16'h0001);
        send_word(rdcw_pkg::ACT_CELL, 16'hA5A5);
        send_word(rdcw_pkg::ACT_CELL, 16'h2222);
        drain_window_out();
        send_word(rdcw_pkg::ACT_CELL, 16'h7FFF);

        // shrink capacity below the current length
        drain_window_out();
        write_length(7'd3);
        send_word(rdcw_pkg::ACT_CELL, 16'h5A5A);
        send_word(rdcw_pkg::ACT_CELL, 16'h8000);
        send_word(rdcw_pkg::ACT_CELL, 16'h5A5A);
        send_word(rdcw_pkg::ACT_STOP, 16'h1234);
        send_word(rdcw_pkg::ACT_CELL, 16'h0042);

        // length below range clamps to capacity 1
        drain_window_out();
        write_length(7'd0);
        send_word(rdcw_pkg::ACT_CELL, 16'h0042);
        send_word(rdcw_pkg::ACT_CELL, 16'h0042);
        send_word(rdcw_pkg::ACT_CELL, 16'h0043);

        run_phase(rdcw_pkg::t_ep'($urandom_range(3, 20)), 30, 1'b0, 5);
        run_phase(7'd1, 15, 1'b0, 5);
        run_phase(7'd127, 70, 1'b1, 0);
        run_phase(7'd2, 15, 1'b0, 5);
        run_phase(rdcw_pkg::t_ep'($urandom_range(0, 127)), 25, 1'b0, 5);
        run_phase(7'd64, 25, 1'b0, 3);
        drain_window_out();

        if (sb.errors == 0 && sb.pending_entries.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
